// ----- rtl/skeleton_forward_kinematics_unit_assert.svh -----
// assertion macros for the skeleton forward kinematics unit
// used by the controller and the top level
`ifndef SKELETON_FORWARD_KINEMATICS_UNIT_ASSERT_SVH
`define SKELETON_FORWARD_KINEMATICS_UNIT_ASSERT_SVH
`define SFK_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define SFK_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// ----- rtl/sfk_pkg.sv -----
// shared types, constants and helpers for the skeleton forward kinematics unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sfk_pkg;
   localparam int MAX_JOINTS_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DATA_W         = 32;
   localparam int COUNT_W        = 7;
   localparam int PARENT_W       = 7;
   localparam int NUM_OUT        = 12;
   localparam int REQ_TDATA_W    = 328;
   localparam int RSP_TDATA_W    = 384;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUAT,
      ST_ROT,
      ST_LOCAL,
      ST_FETCH,
      ST_MODEL,
      ST_OUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       quat_mul;
      logic       rot_sum;
      logic       local_mul;
      logic       fetch;
      logic       model_mul;
      logic       store;
      logic       emit;
      logic [3:0] step;
   } cmd_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [35:0] v);
      logic signed [35:0] hi;
      logic signed [35:0] lo;
      hi = 36'sd2147483647;
      lo = -36'sd2147483648;
      if (v > hi) sat32 = 32'sh7fffffff;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[DATA_W-1:0];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/sfk_datapath.sv -----
// datapath: quaternion, local matrix and parent product with three shared multipliers
// depends on sfk_pkg
`timescale 1ns / 1ps
`default_nettype none
module sfk_datapath #(
   parameter int MAX_JOINTS = sfk_pkg::MAX_JOINTS_DEF,
   parameter int FRAC_BITS  = sfk_pkg::FRAC_BITS_DEF,
   parameter int IDX_W      = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
   input  wire logic                           clock,
   input  wire sfk_pkg::cmd_type               cmd,
   input  wire logic [sfk_pkg::REQ_TDATA_W-1:0] req_data,
   input  wire logic [IDX_W-1:0]               joint_idx,
   output logic                                use_parent,
   output logic [sfk_pkg::RSP_TDATA_W-1:0]     result
);
   import sfk_pkg::*;
   localparam int MEM_D = MAX_JOINTS * NUM_OUT;
   localparam int ADDR_W = $clog2(MEM_D);
   localparam logic signed [35:0] ONE = 36'sd1 <<< FRAC_BITS;

   typedef logic signed [DATA_W-1:0] word_type;

   word_type t_ff [3];
   word_type s_ff [3];
   word_type q_ff [4];
   logic signed [PARENT_W-1:0] parent_ff;
   word_type pr_ff [9];   // xx yy zz xy xz yz wx wy wz
   word_type rot_ff [9];
   word_type loc_ff [12];
   word_type par_ff [12];
   word_type res_ff [12];
   word_type out_ff [12];
   word_type mem [MEM_D];
   word_type rd_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   // three shared multipliers
   word_type ma [3];
   word_type mb [3];
   word_type mp [3];

   function automatic word_type qmul(input word_type a, input word_type b);
      logic signed [63:0] p;
      logic signed [63:0] sh;
      p  = 64'(a) * 64'(b) + (64'sd1 <<< (FRAC_BITS - 1));
      sh = p >>> FRAC_BITS;
      if (sh > 64'sd2147483647) qmul = 32'sh7fffffff;
      else if (sh < -64'sd2147483648) qmul = 32'sh80000000;
      else qmul = sh[DATA_W-1:0];
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ma[i] = '0;
         mb[i] = '0;
      end
      if (cmd.quat_mul) begin
         unique case (cmd.step[1:0])
            2'd0: begin
               ma[0] = q_ff[1]; mb[0] = q_ff[1];
               ma[1] = q_ff[2]; mb[1] = q_ff[2];
               ma[2] = q_ff[3]; mb[2] = q_ff[3];
            end
            2'd1: begin
               ma[0] = q_ff[1]; mb[0] = q_ff[2];
               ma[1] = q_ff[1]; mb[1] = q_ff[3];
               ma[2] = q_ff[2]; mb[2] = q_ff[3];
            end
            default: begin
               ma[0] = q_ff[0]; mb[0] = q_ff[1];
               ma[1] = q_ff[0]; mb[1] = q_ff[2];
               ma[2] = q_ff[0]; mb[2] = q_ff[3];
            end
         endcase
      end else if (cmd.local_mul) begin
         for (int c = 0; c < 3; c++) begin
            ma[c] = rot_ff[int'(cmd.step[1:0]) * 3 + c];
            mb[c] = s_ff[c];
         end
      end else if (cmd.model_mul) begin
         for (int k = 0; k < 3; k++) begin
            ma[k] = par_ff[int'(cmd.step[3:2]) * 4 + k];
            mb[k] = loc_ff[k * 4 + int'(cmd.step[1:0])];
         end
      end
      for (int i = 0; i < 3; i++) mp[i] = qmul(ma[i], mb[i]);
   end

   assign use_parent = !parent_ff[PARENT_W-1]
      && (32'(parent_ff) < 32'(joint_idx));
   assign rd_addr = ADDR_W'(32'(parent_ff[PARENT_W-2:0]) * NUM_OUT + 32'(cmd.step));
   assign wr_addr = ADDR_W'(32'(joint_idx) * NUM_OUT + 32'(cmd.step));

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (cmd.store) mem[wr_addr] <= res_ff[cmd.step];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            t_ff[i] <= req_data[i*32 +: 32];
            s_ff[i] <= req_data[(7+i)*32 +: 32];
         end
         for (int i = 0; i < 4; i++) q_ff[i] <= req_data[(3+i)*32 +: 32];
         parent_ff <= req_data[320 +: PARENT_W];
      end
      if (cmd.quat_mul) begin
         for (int i = 0; i < 3; i++) pr_ff[int'(cmd.step[1:0]) * 3 + i] <= mp[i];
      end
      if (cmd.rot_sum) begin
         rot_ff[0] <= sat32(ONE - 36'sd2 * (36'(pr_ff[1]) + 36'(pr_ff[2])));
         rot_ff[1] <= sat32(36'sd2 * (36'(pr_ff[3]) - 36'(pr_ff[8])));
         rot_ff[2] <= sat32(36'sd2 * (36'(pr_ff[4]) + 36'(pr_ff[7])));
         rot_ff[3] <= sat32(36'sd2 * (36'(pr_ff[3]) + 36'(pr_ff[8])));
         rot_ff[4] <= sat32(ONE - 36'sd2 * (36'(pr_ff[0]) + 36'(pr_ff[2])));
         rot_ff[5] <= sat32(36'sd2 * (36'(pr_ff[5]) - 36'(pr_ff[6])));
         rot_ff[6] <= sat32(36'sd2 * (36'(pr_ff[4]) - 36'(pr_ff[7])));
         rot_ff[7] <= sat32(36'sd2 * (36'(pr_ff[5]) + 36'(pr_ff[6])));
         rot_ff[8] <= sat32(ONE - 36'sd2 * (36'(pr_ff[0]) + 36'(pr_ff[1])));
      end
      if (cmd.local_mul) begin
         for (int c = 0; c < 3; c++) loc_ff[int'(cmd.step[1:0]) * 4 + c] <= mp[c];
         loc_ff[int'(cmd.step[1:0]) * 4 + 3] <= t_ff[cmd.step[1:0]];
      end
      // read data arrives in the cycle after its address
      if (cmd.fetch && cmd.step != 4'd0) par_ff[cmd.step - 4'd1] <= rd_ff;
      if (cmd.model_mul) begin
         res_ff[cmd.step] <= sat32(36'(mp[0]) + 36'(mp[1]) + 36'(mp[2])
            + ((cmd.step[1:0] == 2'd3) ? 36'(par_ff[int'(cmd.step[3:2]) * 4 + 3])
                                         : 36'sd0));
      end
      if (cmd.local_mul && !use_parent) begin
         for (int c = 0; c < 3; c++) res_ff[int'(cmd.step[1:0]) * 4 + c] <= mp[c];
         res_ff[int'(cmd.step[1:0]) * 4 + 3] <= t_ff[cmd.step[1:0]];
      end
      // output register frees the datapath for the next joint
      if (cmd.emit) begin
         for (int i = 0; i < NUM_OUT; i++) out_ff[i] <= res_ff[i];
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_OUT; i++) result[i*32 +: 32] = out_ff[i];
   end
endmodule
`default_nettype wire

// ----- rtl/sfk_controller.sv -----
// controller state machine sequencing the datapath and handshakes
// depends on sfk_pkg and the assertion header
`timescale 1ns / 1ps
`default_nettype none
`include "skeleton_forward_kinematics_unit_assert.svh"
module sfk_controller #(
   parameter int MAX_JOINTS = sfk_pkg::MAX_JOINTS_DEF,
   parameter int IDX_W      = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic                        csr_wen,
   input  wire logic [sfk_pkg::COUNT_W-1:0] csr_wdata,
   input  wire logic                        use_parent,
   output sfk_pkg::cmd_type                 cmd,
   output logic [IDX_W-1:0]                 joint_idx
);
   import sfk_pkg::*;
   localparam int CNT_W = $clog2(MAX_JOINTS + 1);

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [COUNT_W-1:0] count_ff;
   logic [IDX_W-1:0] ctr_ff, ctr_in;
   logic valid_ff, valid_in;
   logic [CNT_W-1:0] eff;
   logic last;
   logic take;

   always_comb begin
      if (count_ff == '0) eff = CNT_W'(1);
      else if (32'(count_ff) > MAX_JOINTS) eff = CNT_W'(MAX_JOINTS);
      else eff = CNT_W'(count_ff);
   end

   assign joint_idx = (32'(ctr_ff) >= 32'(eff)) ? '0 : ctr_ff;
   assign take = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + 4'd1;
      last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (take) state_in = ST_QUAT;
         end
         ST_QUAT: if (step_ff == 4'd2) begin state_in = ST_ROT; step_in = '0; end
         ST_ROT: begin state_in = ST_LOCAL; step_in = '0; end
         ST_LOCAL: if (step_ff == 4'd2) begin
            step_in = '0;
            state_in = use_parent ? ST_FETCH : ST_OUT;
         end
         ST_FETCH: if (step_ff == 4'd12) begin state_in = ST_MODEL; step_in = '0; end
         ST_MODEL: if (step_ff == 4'd11) begin state_in = ST_OUT; step_in = '0; end
         ST_OUT: begin
            if (step_ff == 4'd11) begin
               // wait here while the previous result is still unclaimed
               if (valid_ff && !rsp_tready) begin
                  step_in = step_ff;
               end else begin
                  state_in = ST_IDLE;
                  step_in = '0;
                  last = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.step = step_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE:  begin req_tready = 1'b1; cmd.load = 1'b1; end
         ST_QUAT:  cmd.quat_mul = 1'b1;
         ST_ROT:   cmd.rot_sum = 1'b1;
         ST_LOCAL: cmd.local_mul = 1'b1;
         ST_FETCH: cmd.fetch = 1'b1;
         ST_MODEL: cmd.model_mul = 1'b1;
         ST_OUT:   cmd.store = 1'b1;
         default:  cmd = '0;
      endcase
      cmd.load = cmd.load && take;
      cmd.emit = last;
   end

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tvalid && rsp_tready) valid_in = 1'b0;
      if (last) valid_in = 1'b1;
      ctr_in = ctr_ff;
      if (last) ctr_in = (32'(joint_idx) + 1 >= 32'(eff)) ? '0 : joint_idx + IDX_W'(1);
   end

   assign rsp_tvalid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         ctr_ff   <= '0;
         valid_ff <= 1'b0;
         count_ff <= COUNT_W'(64);
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ctr_ff   <= ctr_in;
         valid_ff <= valid_in;
         if (csr_wen) count_ff <= csr_wdata;
      end
   end

   `SFK_ASSERT_IMP(a_ready_idle, clock, reset, req_tready, state_ff == ST_IDLE)
   `SFK_ASSERT_NEXT(a_last_valid, clock, reset, last, rsp_tvalid)
   `SFK_ASSERT_IMP(a_no_overwrite, clock, reset, last, !rsp_tvalid || rsp_tready)
endmodule
`default_nettype wire

// ----- rtl/skeleton_forward_kinematics_unit.sv -----
// Skeleton forward kinematics unit: one joint per transfer in, one model matrix out.
// For a root or forward parent a joint runs the quaternion products, rotation sums, local
// matrix and store writes on three shared multipliers; with a stored parent the store reads
// and the parent product come before the store writes. A new input transfer is taken only
// in idle, once the previous joint's result is registered. The result sits in an output
// register, so the next joint runs while it waits; that joint holds at its last store write
// until the previous response transfer. Depends on sfk_pkg, sfk_controller, sfk_datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "skeleton_forward_kinematics_unit_assert.svh"
module skeleton_forward_kinematics_unit #(
   parameter int MAX_JOINTS = sfk_pkg::MAX_JOINTS_DEF,
   parameter int FRAC_BITS  = sfk_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // trans_x,y,z quat_w,x,y,z scale_x,y,z parent_index, zero fill
   input  wire logic [sfk_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23
   output logic [sfk_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                            csr_wen,
   input  wire logic [sfk_pkg::COUNT_W-1:0]     csr_wdata
);
   import sfk_pkg::*;
   localparam int IDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   cmd_type cmd;
   logic use_parent;
   logic [IDX_W-1:0] joint_idx;

   sfk_controller #(.MAX_JOINTS(MAX_JOINTS), .IDX_W(IDX_W)) u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .csr_wen, .csr_wdata, .use_parent, .cmd, .joint_idx);

   sfk_datapath #(.MAX_JOINTS(MAX_JOINTS), .FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W)) u_dp (
      .clock, .cmd, .req_data(req_tdata), .joint_idx, .use_parent, .result(rsp_tdata));

   `SFK_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `SFK_ASSERT_NEXT(a_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `SFK_ASSERT_NEXT(a_busy_after_take, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule
`default_nettype wire
